FILE: rtl/mowm_pkg.sv
// Shared types and constants for the max-of-window-minimums block.
package mowm_pkg;

	// Width of the window length field on the result channel.
	localparam int WL_W = 7;

	typedef enum logic [2:0] {
		S_IDLE,
		S_POP,
		S_POPW,
		S_SUF_RD,
		S_SUF_WR,
		S_EM_RD,
		S_EM_LD,
		S_EM_WAIT
	} state_t;

	// Strobes from the controller to the answer table.
	typedef struct packed {
		logic credit;
		logic rd;
		logic wr;
		logic clear;
	} ans_cmd_t;

endpackage

FILE: rtl/mowm_in_if.sv
// Input channel: one sequence element per request.
interface mowm_in_if #(
	parameter int VALUE_WIDTH = 32
);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] value;
	logic                          last;

	modport source (output valid, output value, output last, input ready);
	modport sink (input valid, input value, input last, output ready);
endinterface

FILE: rtl/mowm_out_if.sv
// Result channel: one window length and its best minimum per request.
interface mowm_out_if #(
	parameter int VALUE_WIDTH = 32
);
	import mowm_pkg::*;

	logic                          valid;
	logic                          ready;
	logic [WL_W-1:0]               window_length;
	logic signed [VALUE_WIDTH-1:0] best_minimum;
	logic                          truncated;
	logic                          end_of_run;

	modport source (output valid, output window_length, output best_minimum,
		output truncated, output end_of_run, input ready);
	modport sink (input valid, input window_length, input best_minimum,
		input truncated, input end_of_run, output ready);
endinterface

FILE: rtl/mowm_ans.sv
// Answer table memory with a two-stage read-max-write credit path.
module mowm_ans
	import mowm_pkg::*;
#(
	parameter int MAX_LEN     = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ans_cmd_t                      cmd,
	input  logic [$clog2(MAX_LEN)-1:0]    cr_slot,
	input  logic signed [VALUE_WIDTH-1:0] cr_val,
	input  logic [$clog2(MAX_LEN)-1:0]    rd_addr,
	input  logic [$clog2(MAX_LEN)-1:0]    wr_addr,
	input  logic signed [VALUE_WIDTH-1:0] wr_val,
	output logic signed [VALUE_WIDTH-1:0] rd_data,
	output logic                          busy
);
	localparam int IW = $clog2(MAX_LEN);
	localparam logic [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

	logic [VALUE_WIDTH-1:0]        ans_mem [MAX_LEN];
	logic [MAX_LEN-1:0]            vld_q;
	logic [VALUE_WIDTH-1:0]        rdata_q;
	logic                          rvld_q;
	logic                          cr_s1;
	logic [IW-1:0]                 slot_s1;
	logic signed [VALUE_WIDTH-1:0] val_s1;

	logic                          ren;
	logic [IW-1:0]                 raddr;
	logic signed [VALUE_WIDTH-1:0] cur;
	logic                          wen;
	logic [IW-1:0]                 waddr;
	logic signed [VALUE_WIDTH-1:0] wdata;

	assign ren   = cmd.credit | cmd.rd;
	assign raddr = cmd.credit ? cr_slot : rd_addr;

	// entries not written this sequence read as the most negative value
	assign cur     = rvld_q ? $signed(rdata_q) : $signed(VMIN);
	assign rd_data = cur;
	assign busy    = cr_s1;

	always_comb begin
		wen   = cr_s1 | cmd.wr;
		waddr = cr_s1 ? slot_s1 : wr_addr;
		if (cr_s1) begin
			wdata = (val_s1 > cur) ? val_s1 : cur;
		end else begin
			wdata = wr_val;
		end
	end

	always_ff @(posedge clk) begin
		if (ren) begin
			rdata_q <= ans_mem[raddr];
			rvld_q  <= vld_q[raddr];
		end
		if (wen) begin
			ans_mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		slot_s1 <= cr_slot;
		val_s1  <= cr_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			cr_s1 <= 1'b0;
		end else begin
			cr_s1 <= cmd.credit;
			if (cmd.clear) begin
				vld_q <= '0;
			end else if (wen) begin
				vld_q[waddr] <= 1'b1;
			end
		end
	end

endmodule

FILE: rtl/mowm_ctrl.sv
// Sequencer: index stack memory, pop/credit loop, suffix max and result emit.
module mowm_ctrl
	import mowm_pkg::*;
#(
	parameter int MAX_LEN     = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	mowm_in_if.sink                       in,
	mowm_out_if.source                    out,
	output ans_cmd_t                      cmd,
	output logic [$clog2(MAX_LEN)-1:0]    cr_slot,
	output logic signed [VALUE_WIDTH-1:0] cr_val,
	output logic [$clog2(MAX_LEN)-1:0]    rd_addr,
	output logic [$clog2(MAX_LEN)-1:0]    wr_addr,
	output logic signed [VALUE_WIDTH-1:0] wr_val,
	input  logic signed [VALUE_WIDTH-1:0] rd_data,
	input  logic                          busy
);
	localparam int IW = $clog2(MAX_LEN);
	localparam int CW = $clog2(MAX_LEN + 1);
	localparam logic [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

	state_t state_q, state_d;

	// stack entry: element index above its value
	logic [IW+VALUE_WIDTH-1:0]     stk_mem [MAX_LEN];
	logic [IW+VALUE_WIDTH-1:0]     stk_rd_q;
	logic [IW-1:0]                 stk_rd_idx;
	logic signed [VALUE_WIDTH-1:0] stk_rd_val;

	logic [CW-1:0]                 cnt_q;
	logic [CW-1:0]                 depth_q;
	logic                          ovf_q;
	logic                          drain_q;
	logic                          last_q;
	logic signed [VALUE_WIDTH-1:0] v_q;
	logic signed [VALUE_WIDTH-1:0] top_val_q;
	logic signed [VALUE_WIDTH-1:0] pv_q;
	logic signed [VALUE_WIDTH-1:0] run_q;
	logic [IW-1:0]                 k_q;

	logic [WL_W-1:0]               owl_q;
	logic signed [VALUE_WIDTH-1:0] obest_q;
	logic                          otr_q;
	logic                          oeor_q;
	logic                          ovalid_q;

	logic                          in_acc;
	logic                          out_acc;
	logic                          full;
	logic                          pop_go;
	logic                          push;
	logic [IW-1:0]                 n_last_k;
	logic signed [VALUE_WIDTH-1:0] run_nx;

	assign in_acc     = in.valid && in.ready;
	assign out_acc    = out.valid && out.ready;
	assign full       = (cnt_q == CW'(MAX_LEN));
	assign pop_go     = (depth_q != '0) && (drain_q || (v_q < top_val_q));
	assign push       = (state_q == S_POP) && !pop_go && !drain_q;
	assign n_last_k   = IW'(cnt_q - CW'(1));
	assign stk_rd_idx = stk_rd_q[IW+VALUE_WIDTH-1:VALUE_WIDTH];
	assign stk_rd_val = $signed(stk_rd_q[VALUE_WIDTH-1:0]);
	assign run_nx     = (rd_data > run_q) ? rd_data : run_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				// a dropped element without last needs no further work
				if (in_acc && (!full || in.last)) begin
					state_d = S_POP;
				end
			end
			S_POP: begin
				if (pop_go) begin
					state_d = S_POPW;
				end else if (drain_q) begin
					state_d = S_SUF_RD;
				end else if (!last_q) begin
					state_d = S_IDLE;
				end
			end
			S_POPW: state_d = S_POP;
			S_SUF_RD: begin
				if (!busy) begin
					state_d = S_SUF_WR;
				end
			end
			S_SUF_WR: state_d = (k_q == '0) ? S_EM_RD : S_SUF_RD;
			S_EM_RD: state_d = S_EM_LD;
			S_EM_LD: state_d = S_EM_WAIT;
			S_EM_WAIT: begin
				if (out_acc) begin
					state_d = oeor_q ? S_IDLE : S_EM_LD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs and memory strobes
	always_comb begin
		in.ready   = 1'b0;
		cmd        = '0;
		rd_addr    = k_q;
		wr_addr    = k_q;
		wr_val     = run_nx;
		cr_val     = pv_q;
		if (depth_q == '0) begin
			cr_slot = n_last_k;
		end else begin
			cr_slot = IW'(cnt_q - CW'(stk_rd_idx) - CW'(2));
		end
		case (state_q)
			S_IDLE: in.ready = 1'b1;
			S_POPW: cmd.credit = 1'b1;
			S_SUF_RD: cmd.rd = !busy;
			S_SUF_WR: cmd.wr = 1'b1;
			S_EM_RD: cmd.rd = 1'b1;
			S_EM_WAIT: begin
				rd_addr   = k_q + IW'(1);
				cmd.rd    = out_acc && !oeor_q;
				cmd.clear = out_acc && oeor_q;
			end
			default: begin
			end
		endcase
	end

	assign out.valid         = ovalid_q;
	assign out.window_length = owl_q;
	assign out.best_minimum  = obest_q;
	assign out.truncated     = otr_q;
	assign out.end_of_run    = oeor_q;

	// stack memory: read the entry under the top while popping
	always_ff @(posedge clk) begin
		if (state_q == S_POP) begin
			stk_rd_q <= stk_mem[IW'(depth_q - CW'(2))];
		end
		if (push) begin
			stk_mem[IW'(depth_q)] <= {IW'(cnt_q), v_q};
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			v_q    <= in.value;
			last_q <= in.last;
		end
		case (state_q)
			S_POP: begin
				if (pop_go) begin
					pv_q <= top_val_q;
				end else if (drain_q) begin
					k_q   <= n_last_k;
					run_q <= $signed(VMIN);
				end else begin
					top_val_q <= v_q;
				end
			end
			S_POPW: begin
				if (depth_q != '0) begin
					top_val_q <= stk_rd_val;
				end
			end
			S_SUF_WR: begin
				run_q <= run_nx;
				if (k_q != '0) begin
					k_q <= k_q - IW'(1);
				end
			end
			S_EM_LD: begin
				owl_q   <= WL_W'(k_q) + WL_W'(1);
				obest_q <= rd_data;
				otr_q   <= ovf_q;
				oeor_q  <= (k_q == n_last_k);
			end
			S_EM_WAIT: begin
				if (out_acc && !oeor_q) begin
					k_q <= k_q + IW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			depth_q  <= '0;
			ovf_q    <= 1'b0;
			drain_q  <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						// store full: drop element, drain directly if it ends the run
						if (full) begin
							ovf_q <= 1'b1;
						end
						drain_q <= full && in.last;
					end
				end
				S_POP: begin
					if (pop_go) begin
						depth_q <= depth_q - CW'(1);
					end else if (!drain_q) begin
						depth_q <= depth_q + CW'(1);
						cnt_q   <= cnt_q + CW'(1);
						drain_q <= last_q;
					end
				end
				S_EM_LD: ovalid_q <= 1'b1;
				S_EM_WAIT: begin
					if (out_acc) begin
						ovalid_q <= 1'b0;
						if (oeor_q) begin
							cnt_q   <= '0;
							depth_q <= '0;
							ovf_q   <= 1'b0;
							drain_q <= 1'b0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

FILE: rtl/max_of_window_minimums_stack.sv
// Elements are taken only while idle; each pops the stack entries larger than it, then is pushed.
// The last element also pops all entries left on the stack, then a suffix-max sweep runs
// over the answer memory, then the results are emitted one per window length.
// A dropped element without last only sets the overflow flag. Result-side stalls hold the emit.
// Reset clears control and the answer table valid bits at once; no clearing pass.
// Stack and element contents are undefined after reset until written.
module max_of_window_minimums_stack
	import mowm_pkg::*;
#(
	parameter int MAX_LEN     = 64,
	parameter int VALUE_WIDTH = 32
) (
	input logic        clk,
	input logic        arst_n,
	mowm_in_if.sink    in,
	mowm_out_if.source out
);
	localparam int IW = $clog2(MAX_LEN);

	ans_cmd_t                      cmd;
	logic [IW-1:0]                 cr_slot;
	logic signed [VALUE_WIDTH-1:0] cr_val;
	logic [IW-1:0]                 rd_addr;
	logic [IW-1:0]                 wr_addr;
	logic signed [VALUE_WIDTH-1:0] wr_val;
	logic signed [VALUE_WIDTH-1:0] rd_data;
	logic                          busy;

	mowm_ctrl #(
		.MAX_LEN     (MAX_LEN),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in      (in),
		.out     (out),
		.cmd     (cmd),
		.cr_slot (cr_slot),
		.cr_val  (cr_val),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.wr_val  (wr_val),
		.rd_data (rd_data),
		.busy    (busy)
	);

	mowm_ans #(
		.MAX_LEN     (MAX_LEN),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_ans (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.cr_slot (cr_slot),
		.cr_val  (cr_val),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.wr_val  (wr_val),
		.rd_data (rd_data),
		.busy    (busy)
	);

endmodule

FILE: tb/max_of_window_minimums_stack_tb.sv
// Testbench for max_of_window_minimums_stack: directed and random sequences checked against a predictor.
`timescale 1ns / 100ps

module max_of_window_minimums_stack_tb;
	import mowm_pkg::*;

	localparam int MAX_LEN     = 64;
	localparam int VW          = 32;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 400;
	localparam logic signed [VW-1:0] MOST_NEG = {1'b1, {(VW-1){1'b0}}};
	localparam logic signed [VW-1:0] MOST_POS = {1'b0, {(VW-1){1'b1}}};

	typedef struct {
		logic [WL_W-1:0]      window_length;
		logic signed [VW-1:0] best_minimum;
		logic                 truncated;
		logic                 end_of_run;
	} window_result_t;

	logic clk = 1'b0;
	logic arst_n;

	mowm_in_if #(.VALUE_WIDTH(VW)) in_ch ();
	mowm_out_if #(.VALUE_WIDTH(VW)) out_ch ();

	max_of_window_minimums_stack #(
		.MAX_LEN(MAX_LEN),
		.VALUE_WIDTH(VW)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in(in_ch),
		.out(out_ch)
	);

	always #1 clk = ~clk;

	// Predictor state
	logic signed [VW-1:0] elem_mem [MAX_LEN];
	int                   idx_stk [MAX_LEN];
	int                   stk_depth;
	int                   elem_count;
	bit                   overflow_flag;
	logic signed [VW-1:0] best_tab [MAX_LEN];

	window_result_t pending_windows [$];
	window_result_t head_window;

	int fail_count;
	int sent_items;
	bit idle_on;
	bit hold_req;

	task automatic start_new_sequence();
		int k;
		for (k = 0; k < MAX_LEN; k++) begin
			best_tab[k] = MOST_NEG;
		end
		stk_depth     = 0;
		elem_count    = 0;
		overflow_flag = 1'b0;
	endtask

	function automatic void credit_span(int span, logic signed [VW-1:0] pv);
		int slot;
		slot = (span - 1) % MAX_LEN;
		if (pv > best_tab[slot])
			best_tab[slot] = pv;
	endfunction

	// Mirrors the block on one accepted element; queues results on last.
	task automatic track_element(input logic signed [VW-1:0] v, input logic lst);
		int i;
		int span;
		int n;
		int k;
		logic signed [VW-1:0] pv;
		window_result_t r;
		if (elem_count < MAX_LEN) begin
			i = elem_count;
			// strictly larger entries are popped; equal values stay
			while (stk_depth > 0 && v < elem_mem[idx_stk[stk_depth-1]]) begin
				stk_depth--;
				pv   = elem_mem[idx_stk[stk_depth]];
				span = (stk_depth == 0) ? i : i - idx_stk[stk_depth-1] - 1;
				credit_span(span, pv);
			end
			elem_mem[i]        = v;
			idx_stk[stk_depth] = i;
			stk_depth++;
			elem_count++;
		end else begin
			overflow_flag = 1'b1;
		end
		if (lst) begin
			n = elem_count;
			while (stk_depth > 0) begin
				stk_depth--;
				pv   = elem_mem[idx_stk[stk_depth]];
				span = (stk_depth == 0) ? n : n - 1 - idx_stk[stk_depth-1];
				credit_span(span, pv);
			end
			for (k = n - 1; k > 0; k--) begin
				if (best_tab[k] > best_tab[k-1])
					best_tab[k-1] = best_tab[k];
			end
			for (k = 0; k < n; k++) begin
				r.window_length = WL_W'(k + 1);
				r.best_minimum  = best_tab[k];
				r.truncated     = overflow_flag;
				r.end_of_run    = (k + 1 == n);
				pending_windows.push_back(r);
			end
			start_new_sequence();
		end
	endtask

	task automatic send_element(input logic signed [VW-1:0] v, input logic lst);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.value <= v;
		in_ch.last  <= lst;
		// ready is sampled as it stands at the edge
		@(posedge clk iff in_ch.ready);
		track_element(v, lst);
		sent_items++;
	endtask

	// mode 0: full range, 1: narrow range (many ties), else: mostly extremes
	function automatic logic signed [VW-1:0] pick_value(int mode);
		case (mode)
			0: return $urandom;
			1: return int'($urandom_range(0, 6)) - 3;
			default: begin
				case ($urandom_range(0, 4))
					0: return MOST_NEG;
					1: return MOST_POS;
					2: return 0;
					3: return -1;
					default: return $urandom;
				endcase
			end
		endcase
	endfunction

	task automatic send_sequence(input int len, input int mode);
		int j;
		for (j = 0; j < len; j++) begin
			send_element(pick_value(mode), j == len - 1);
		end
	endtask

	task automatic test_extremes();
		send_element(MOST_NEG, 1'b1);
		send_element(MOST_POS, 1'b1);
		send_element(MOST_POS, 1'b0);
		send_element(MOST_NEG, 1'b0);
		send_element(0, 1'b0);
		send_element(-1, 1'b1);
	endtask

	task automatic test_equal_values();
		send_element(5, 1'b0);
		send_element(5, 1'b0);
		send_element(5, 1'b1);
		send_element(-7, 1'b0);
		send_element(2, 1'b0);
		send_element(-7, 1'b1);
	endtask

	task automatic test_monotonic();
		int j;
		for (j = 1; j <= 4; j++) begin
			send_element(j, j == 4);
		end
		for (j = 4; j >= 1; j--) begin
			send_element(j, j == 1);
		end
	endtask

	// exactly full, then full with dropped elements (last on a dropped one)
	task automatic test_capacity();
		send_sequence(MAX_LEN, 0);
		send_sequence(MAX_LEN + 2, 2);
	endtask

	// receiver holds off while several sequences are offered
	task automatic test_pressure();
		int j;
		hold_req = 1'b1;
		for (j = 0; j < 4; j++) begin
			send_sequence(6, j % 3);
		end
	endtask

	task automatic test_random_traffic(input int item_goal);
		int start_count;
		int len;
		int pick;
		start_count = sent_items;
		while (sent_items - start_count < item_goal) begin
			pick = $urandom_range(0, 11);
			if (pick == 0)
				len = MAX_LEN;
			else if (pick == 1)
				len = $urandom_range(MAX_LEN + 1, MAX_LEN + 4);
			else
				len = $urandom_range(1, 16);
			send_sequence(len, $urandom_range(0, 2));
		end
	endtask

	// Result checker
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_windows.size() == 0) begin
				$error("unexpected result: window_length %0d best_minimum %0d",
					out_ch.window_length, out_ch.best_minimum);
				fail_count++;
			end else begin
				head_window = pending_windows.pop_front();
				if (out_ch.window_length !== head_window.window_length) begin
					$error("window_length: expected %0d, actual %0d",
						head_window.window_length, out_ch.window_length);
					fail_count++;
				end
				if (out_ch.best_minimum !== head_window.best_minimum) begin
					$error("best_minimum: expected %0d, actual %0d",
						head_window.best_minimum, out_ch.best_minimum);
					fail_count++;
				end
				if (out_ch.truncated !== head_window.truncated) begin
					$error("truncated: expected %0d, actual %0d",
						head_window.truncated, out_ch.truncated);
					fail_count++;
				end
				if (out_ch.end_of_run !== head_window.end_of_run) begin
					$error("end_of_run: expected %0d, actual %0d",
						head_window.end_of_run, out_ch.end_of_run);
					fail_count++;
				end
			end
		end
	end

	// Result-side ready: random stall bursts, plus a long hold when requested
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				out_ch.ready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				out_ch.ready <= 1'b1;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		#1000000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		arst_n       = 1'b0;
		in_ch.valid  = 1'b0;
		in_ch.value  = '0;
		in_ch.last   = 1'b0;
		out_ch.ready = 1'b0;
		fail_count   = 0;
		sent_items   = 0;
		idle_on      = 1'b1;
		hold_req     = 1'b0;
		start_new_sequence();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_equal_values();
		test_monotonic();
		test_capacity();
		test_pressure();
		test_random_traffic(130);
		idle_on = 1'b0;
		test_random_traffic(50);
		in_ch.valid <= 1'b0;

		while (pending_windows.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/mowm_pkg.sv
rtl/mowm_in_if.sv
rtl/mowm_out_if.sv
rtl/mowm_ans.sv
rtl/mowm_ctrl.sv
rtl/max_of_window_minimums_stack.sv
tb/max_of_window_minimums_stack_tb.sv
